@@ rtl/gnl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient noise lattice package
// Shared widths, fixed-point constants, codes and helper functions.
// ----------------------------------------------------------------------------
package gnl_pkg;

  localparam int FRAC      = 16;
  localparam int HASH_W    = 8;
  localparam int TBL_DEPTH = 256;
  localparam int COORD_W   = 32;
  localparam int OUT_W     = 19;
  localparam int VAL_W     = 24;
  localparam int FADE_W    = 19;
  localparam int FADE_C_W  = FRAC + 6;
  localparam int MUL_W     = 48;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] DIM_2 = 2'd2;
  localparam logic [1:0] DIM_3 = 2'd3;
  localparam logic [1:0] DIM_RESET = DIM_3;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [FADE_W-1:0] fade_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic [HASH_W-1:0]        hash_t;

  localparam val_t ONE_V   = val_t'(1) <<< FRAC;
  localparam val_t HALF_V  = val_t'(1) <<< (FRAC - 1);
  localparam val_t OUT_MAX = val_t'((1 << (OUT_W - 1)) - 1);
  localparam val_t OUT_MIN = val_t'(-(1 << (OUT_W - 1)));

  // sqrt(2)/2 rounded to nearest at FRAC fraction bits.
  localparam logic signed [FRAC+1:0] HALF_SQRT2 =
    (FRAC+2)'((64'sd759250125 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));

  localparam logic signed [FADE_C_W-1:0] FIFTEEN_Q = FADE_C_W'(15) <<< FRAC;
  localparam logic signed [FADE_C_W-1:0] TEN_Q     = FADE_C_W'(10) <<< FRAC;

  typedef struct packed {
    logic  we;
    hash_t addr;
    hash_t data;
  } tbl_wr_t;

  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad_t;

  localparam logic signed [1:0] GP = 2'sd1;
  localparam logic signed [1:0] GN = -2'sd1;
  localparam logic signed [1:0] G0 = 2'sd0;

  function automatic grad_t grad3(input logic [3:0] h);
    grad_t g;
    unique case (h)
      4'd0:    g = '{GP, GP, G0};
      4'd1:    g = '{GN, GP, G0};
      4'd2:    g = '{GP, GN, G0};
      4'd3:    g = '{GN, GN, G0};
      4'd4:    g = '{GP, G0, GP};
      4'd5:    g = '{GN, G0, GP};
      4'd6:    g = '{GP, G0, GN};
      4'd7:    g = '{GN, G0, GN};
      4'd8:    g = '{G0, GP, GP};
      4'd9:    g = '{G0, GN, GP};
      4'd10:   g = '{G0, GP, GN};
      4'd11:   g = '{G0, GN, GN};
      4'd12:   g = '{GP, GP, G0};
      4'd13:   g = '{GN, GP, G0};
      4'd14:   g = '{G0, GN, GP};
      default: g = '{G0, GN, GN};
    endcase
    return g;
  endfunction

  function automatic val_t gterm(input logic signed [1:0] g, input val_t d);
    val_t r;
    if (g == GP) begin
      r = d;
    end else if (g == GN) begin
      r = -d;
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/gnl_perm_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Permutation table copy
// One write port and two registered read ports, all advancing with the pipe.
// ----------------------------------------------------------------------------
module gnl_perm_mem (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire gnl_pkg::tbl_wr_t wr,
  input  wire gnl_pkg::hash_t  rd_addr_a,
  input  wire gnl_pkg::hash_t  rd_addr_b,
  output gnl_pkg::hash_t       rd_data_a,
  output gnl_pkg::hash_t       rd_data_b
);

  gnl_pkg::hash_t mem [gnl_pkg::TBL_DEPTH];
  gnl_pkg::hash_t rd_a_r;
  gnl_pkg::hash_t rd_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.we) begin
        mem[wr.addr] <= wr.data;
      end
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule
`default_nettype wire

@@ rtl/gnl_fade.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quintic fade
// Three-stage pipeline computing 6t^5 - 15t^4 + 10t^3 with floored products.
// ----------------------------------------------------------------------------
module gnl_fade (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [gnl_pkg::FRAC-1:0] t,
  output gnl_pkg::fade_t                fade
);

  logic signed [gnl_pkg::FRAC:0]       ts;
  logic signed [gnl_pkg::FADE_C_W-1:0] c;
  gnl_pkg::mul_t                       t2_m;
  gnl_pkg::mul_t                       q_m;
  gnl_pkg::mul_t                       t3_m;
  gnl_pkg::mul_t                       f_m;

  logic signed [gnl_pkg::FRAC:0]       t1_r;
  logic signed [gnl_pkg::FRAC:0]       t2_r;
  logic signed [gnl_pkg::FADE_C_W-1:0] q_r;
  logic signed [gnl_pkg::FRAC:0]       t3_r;
  logic signed [gnl_pkg::FADE_C_W-1:0] p_r;
  gnl_pkg::fade_t                      fade_r;

  always_comb begin
    ts   = $signed({1'b0, t});
    c    = (gnl_pkg::FADE_C_W'(ts) <<< 2) + (gnl_pkg::FADE_C_W'(ts) <<< 1)
           - gnl_pkg::FIFTEEN_Q;
    t2_m = (gnl_pkg::mul_t'(ts) * gnl_pkg::mul_t'(ts)) >>> gnl_pkg::FRAC;
    q_m  = (gnl_pkg::mul_t'(ts) * gnl_pkg::mul_t'(c)) >>> gnl_pkg::FRAC;
    t3_m = (gnl_pkg::mul_t'(t2_r) * gnl_pkg::mul_t'(t1_r)) >>> gnl_pkg::FRAC;
    f_m  = (gnl_pkg::mul_t'(t3_r) * gnl_pkg::mul_t'(p_r)) >>> gnl_pkg::FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= ts;
      t2_r   <= t2_m[gnl_pkg::FRAC:0];
      q_r    <= q_m[gnl_pkg::FADE_C_W-1:0];
      t3_r   <= t3_m[gnl_pkg::FRAC:0];
      p_r    <= q_r + gnl_pkg::TEN_Q;
      fade_r <= f_m[gnl_pkg::FADE_W-1:0];
    end
  end

  assign fade = fade_r;

endmodule
`default_nettype wire

@@ rtl/gradient_noise_lattice.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient noise lattice
// Pipelined 1D/2D/3D lattice gradient noise with a loadable permutation table.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_ channel (valid/stall). A request with
// in_kind low writes in_table_value into permutation entry in_table_index
// and produces no result. A request with in_kind high evaluates noise at the
// signed Q16.16 point (in_coord_x, in_coord_y, in_coord_z) and produces one
// Q2.16 result on the out_ channel. The cfg_ port writes the dimension count
// (1, 2 or 3; 0 behaves as 1); the user must write it only while the block
// is empty, which the block does not enforce. One request is accepted in
// every cycle unless the pipe is stalled. The rate is set by the ten-stage
// pipeline: the table is held as seven copies, one per chained lookup pair,
// so every hashing level reads from its own ports in its own stage.
// Loads ripple down the pipe and update each copy in order with evaluations.
// Reset clears the pipeline valid bits and sets the dimension count to 3;
// the table contents are undefined until loaded and every entry used must be
// loaded first. When the receiver stalls with a result waiting, the whole
// pipe freezes and in_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_noise_lattice (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [1:0]                             cfg_wr_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_kind,
  input  wire logic [7:0]                             in_table_index,
  input  wire logic [7:0]                             in_table_value,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]     in_coord_x,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]     in_coord_y,
  input  wire logic signed [gnl_pkg::COORD_W-1:0]     in_coord_z,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [gnl_pkg::OUT_W-1:0]            out_noise_value
);

  localparam int F = gnl_pkg::FRAC;

  logic en;
  logic [1:0] dims_r;

  // Stage 1: captured request.
  logic s1_v_r, s1_kind_r;
  gnl_pkg::hash_t s1_cx_r, s1_cy_r, s1_cz_r, s1_tidx_r, s1_tval_r;
  logic [F-1:0] s1_fx_r, s1_fy_r, s1_fz_r;
  // Stage 2.
  logic s2_v_r, s2_kind_r;
  gnl_pkg::hash_t s2_cy_r, s2_cz_r, s2_tidx_r, s2_tval_r;
  logic [F-1:0] s2_fx_r, s2_fy_r, s2_fz_r;
  // Stage 3.
  logic s3_v_r, s3_kind_r;
  gnl_pkg::hash_t s3_cz_r, s3_tidx_r, s3_tval_r;
  logic [F-1:0] s3_fx_r, s3_fy_r, s3_fz_r;
  gnl_pkg::hash_t s3_hl1_r [2];
  // Stage 4.
  logic s4_v_r, s4_kind_r;
  logic [F-1:0] s4_fx_r, s4_fy_r, s4_fz_r;
  gnl_pkg::hash_t s4_hl1_r [2];
  gnl_pkg::hash_t s4_hl2_r [4];
  // Stage 5 and 6: corner values.
  logic s5_v_r, s5_kind_r, s6_v_r, s6_kind_r;
  gnl_pkg::val_t s5_pre_r [8];
  gnl_pkg::val_t s6_pre_r [8];
  logic [7:0] s5_flag_r, s6_flag_r;
  gnl_pkg::mul_t s6_prod_r [8];
  gnl_pkg::fade_t s5_u_r, s5_w_r, s5_s_r, s6_u_r, s6_w_r, s6_s_r;
  // Stage 7 to 10: nested interpolation and scaling.
  logic s7_v_r, s7_kind_r, s8_v_r, s8_kind_r, s9_v_r, s9_kind_r;
  logic s10_v_r, s10_kind_r;
  gnl_pkg::val_t s7_xa_r [4];
  gnl_pkg::mul_t s7_xm_r [4];
  gnl_pkg::fade_t s7_w_r, s7_s_r, s8_s_r;
  gnl_pkg::val_t s8_x0_r, s9_x0_r, s9_y0_r;
  gnl_pkg::val_t s8_ya_r [2];
  gnl_pkg::mul_t s8_ym_r [2];
  gnl_pkg::val_t s9_za_r;
  gnl_pkg::mul_t s9_zm_r;
  gnl_pkg::val_t s10_fin_r;
  // Output register.
  logic out_valid_r;
  logic signed [gnl_pkg::OUT_W-1:0] out_noise_value_r;

  // Table read data and write ports.
  gnl_pkg::hash_t hl1 [2];
  gnl_pkg::hash_t hl2 [4];
  gnl_pkg::hash_t hl3 [8];
  gnl_pkg::tbl_wr_t wr_l1, wr_l2, wr_l3;
  gnl_pkg::fade_t fade_u, fade_w, fade_s;

  // Combinational stage results.
  gnl_pkg::val_t pre [8];
  logic [7:0] flag;
  gnl_pkg::mul_t prod [8];
  gnl_pkg::val_t corner [8];
  logic signed [gnl_pkg::VAL_W:0] xd [4];
  gnl_pkg::mul_t xm [4];
  gnl_pkg::val_t xl [4];
  logic signed [gnl_pkg::VAL_W:0] yd [2];
  gnl_pkg::mul_t ym [2];
  gnl_pkg::val_t yl [2];
  logic signed [gnl_pkg::VAL_W:0] zd;
  gnl_pkg::mul_t zm;
  gnl_pkg::mul_t zmsh;
  gnl_pkg::val_t zl;
  gnl_pkg::val_t fin;
  gnl_pkg::mul_t sc_m;
  gnl_pkg::val_t scaled;
  gnl_pkg::val_t biased;
  logic signed [gnl_pkg::OUT_W-1:0] sat;

  // The pipe advances unless a finished result is held by the receiver.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= gnl_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      dims_r <= cfg_wr_data;
    end
  end

  // Valid bits and the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
      s5_v_r <= 1'b0; s6_v_r <= 1'b0; s7_v_r <= 1'b0; s8_v_r <= 1'b0;
      s9_v_r <= 1'b0; s10_v_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= s8_v_r;
      s10_v_r     <= s9_v_r;
      out_valid_r <= s10_v_r && (s10_kind_r == gnl_pkg::KIND_EVAL);
    end
  end

  // Table copies: level one (cell x), level two (plus cell y), level three
  // (plus cell z). Each level is written when a load passes its stage.
  assign wr_l1 = '{we: s1_v_r && (s1_kind_r == gnl_pkg::KIND_LOAD),
                   addr: s1_tidx_r, data: s1_tval_r};
  assign wr_l2 = '{we: s2_v_r && (s2_kind_r == gnl_pkg::KIND_LOAD),
                   addr: s2_tidx_r, data: s2_tval_r};
  assign wr_l3 = '{we: s3_v_r && (s3_kind_r == gnl_pkg::KIND_LOAD),
                   addr: s3_tidx_r, data: s3_tval_r};

  gnl_perm_mem u_mem_l1 (
    .clk       (clk),
    .en        (en),
    .wr        (wr_l1),
    .rd_addr_a (s1_cx_r),
    .rd_addr_b (s1_cx_r + 8'd1),
    .rd_data_a (hl1[0]),
    .rd_data_b (hl1[1])
  );

  for (genvar g = 0; g < 2; g++) begin : g_l2
    gnl_perm_mem u_mem_l2 (
      .clk       (clk),
      .en        (en),
      .wr        (wr_l2),
      .rd_addr_a (hl1[g] + s2_cy_r),
      .rd_addr_b (hl1[g] + s2_cy_r + 8'd1),
      .rd_data_a (hl2[2*g]),
      .rd_data_b (hl2[2*g+1])
    );
  end

  for (genvar g = 0; g < 4; g++) begin : g_l3
    gnl_perm_mem u_mem_l3 (
      .clk       (clk),
      .en        (en),
      .wr        (wr_l3),
      .rd_addr_a (hl2[g] + s3_cz_r),
      .rd_addr_b (hl2[g] + s3_cz_r + 8'd1),
      .rd_data_a (hl3[2*g]),
      .rd_data_b (hl3[2*g+1])
    );
  end

  // Fade units run alongside the hashing stages; results line up at stage 4.
  gnl_fade u_fade_x (.clk(clk), .en(en), .t(s1_fx_r), .fade(fade_u));
  gnl_fade u_fade_y (.clk(clk), .en(en), .t(s1_fy_r), .fade(fade_w));
  gnl_fade u_fade_z (.clk(clk), .en(en), .t(s1_fz_r), .fade(fade_s));

  // Corner dot products. Corner index is {x, y, z}.
  always_comb begin
    gnl_pkg::val_t dx, dy, dz;
    gnl_pkg::grad_t g;
    gnl_pkg::hash_t h2;
    logic [1:0] j;
    for (int i = 0; i < 8; i++) begin
      dx = gnl_pkg::val_t'({{(gnl_pkg::VAL_W-F){1'b0}}, s4_fx_r})
           - (i[2] ? gnl_pkg::ONE_V : gnl_pkg::val_t'(0));
      dy = gnl_pkg::val_t'({{(gnl_pkg::VAL_W-F){1'b0}}, s4_fy_r})
           - (i[1] ? gnl_pkg::ONE_V : gnl_pkg::val_t'(0));
      dz = gnl_pkg::val_t'({{(gnl_pkg::VAL_W-F){1'b0}}, s4_fz_r})
           - (i[0] ? gnl_pkg::ONE_V : gnl_pkg::val_t'(0));
      g  = gnl_pkg::grad3(hl3[i][3:0]);
      j  = {i[2], i[1]};
      h2 = s4_hl2_r[j];
      pre[i]  = '0;
      flag[i] = 1'b0;
      unique case (dims_r)
        gnl_pkg::DIM_3: begin
          pre[i] = gnl_pkg::gterm(g.gx, dx) + gnl_pkg::gterm(g.gy, dy)
                   + gnl_pkg::gterm(g.gz, dz);
        end
        gnl_pkg::DIM_2: begin
          if (!i[0]) begin
            // The upper half of the eight gradients is diagonal and scaled.
            flag[i] = h2[2];
            unique case (h2[2:0])
              3'd0:    pre[i] = dx;
              3'd1:    pre[i] = -dx;
              3'd2:    pre[i] = dy;
              3'd3:    pre[i] = -dy;
              3'd4:    pre[i] = dx + dy;
              3'd5:    pre[i] = dy - dx;
              3'd6:    pre[i] = dx - dy;
              default: pre[i] = -dx - dy;
            endcase
          end
        end
        default: begin
          if (i[1:0] == 2'd0) begin
            pre[i] = s4_hl1_r[i[2]][0] ? -dx : dx;
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      prod[i]   = (gnl_pkg::mul_t'(s5_pre_r[i]) * gnl_pkg::mul_t'(gnl_pkg::HALF_SQRT2))
                  >>> F;
      corner[i] = s6_flag_r[i] ? gnl_pkg::val_t'(s6_prod_r[i][gnl_pkg::VAL_W-1:0])
                               : s6_pre_r[i];
    end
    // Interpolate along x: pairs differ in the x bit of the corner index.
    for (int j = 0; j < 4; j++) begin
      xd[j] = (gnl_pkg::VAL_W+1)'(corner[4+j]) - (gnl_pkg::VAL_W+1)'(corner[j]);
      xm[j] = gnl_pkg::mul_t'(xd[j]) * gnl_pkg::mul_t'(s6_u_r);
    end
    for (int j = 0; j < 4; j++) begin
      xl[j] = s7_xa_r[j] + gnl_pkg::val_t'(s7_xm_r[j][gnl_pkg::VAL_W+F-1:F]);
    end
    for (int k = 0; k < 2; k++) begin
      yd[k] = (gnl_pkg::VAL_W+1)'(xl[2+k]) - (gnl_pkg::VAL_W+1)'(xl[k]);
      ym[k] = gnl_pkg::mul_t'(yd[k]) * gnl_pkg::mul_t'(s7_w_r);
      yl[k] = s8_ya_r[k] + gnl_pkg::val_t'(s8_ym_r[k][gnl_pkg::VAL_W+F-1:F]);
    end
    zd   = (gnl_pkg::VAL_W+1)'(yl[1]) - (gnl_pkg::VAL_W+1)'(yl[0]);
    zm   = gnl_pkg::mul_t'(zd) * gnl_pkg::mul_t'(s8_s_r);
    zmsh = s9_zm_r >>> F;
    zl   = s9_za_r + gnl_pkg::val_t'(zmsh[gnl_pkg::VAL_W-1:0]);
  end

  // Final selection, scaling, centring and saturation.
  always_comb begin
    unique case (dims_r)
      gnl_pkg::DIM_3: fin = zl;
      gnl_pkg::DIM_2: fin = s9_y0_r;
      default:        fin = s9_x0_r;
    endcase
    sc_m = (gnl_pkg::mul_t'(s10_fin_r) * gnl_pkg::mul_t'(gnl_pkg::HALF_SQRT2)) >>> F;
    unique case (dims_r)
      gnl_pkg::DIM_3: scaled = s10_fin_r >>> 1;
      gnl_pkg::DIM_2: scaled = gnl_pkg::val_t'(sc_m[gnl_pkg::VAL_W-1:0]);
      default:        scaled = s10_fin_r;
    endcase
    biased = scaled + gnl_pkg::HALF_V;
    priority if (biased > gnl_pkg::OUT_MAX) begin
      sat = gnl_pkg::OUT_MAX[gnl_pkg::OUT_W-1:0];
    end else if (biased < gnl_pkg::OUT_MIN) begin
      sat = gnl_pkg::OUT_MIN[gnl_pkg::OUT_W-1:0];
    end else begin
      sat = biased[gnl_pkg::OUT_W-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_kind;
      s1_cx_r   <= in_coord_x[F+7:F];
      s1_cy_r   <= in_coord_y[F+7:F];
      s1_cz_r   <= in_coord_z[F+7:F];
      s1_fx_r   <= in_coord_x[F-1:0];
      s1_fy_r   <= in_coord_y[F-1:0];
      s1_fz_r   <= in_coord_z[F-1:0];
      s1_tidx_r <= in_table_index;
      s1_tval_r <= in_table_value;

      s2_kind_r <= s1_kind_r;
      s2_cy_r   <= s1_cy_r;
      s2_cz_r   <= s1_cz_r;
      s2_fx_r   <= s1_fx_r;
      s2_fy_r   <= s1_fy_r;
      s2_fz_r   <= s1_fz_r;
      s2_tidx_r <= s1_tidx_r;
      s2_tval_r <= s1_tval_r;

      s3_kind_r <= s2_kind_r;
      s3_cz_r   <= s2_cz_r;
      s3_fx_r   <= s2_fx_r;
      s3_fy_r   <= s2_fy_r;
      s3_fz_r   <= s2_fz_r;
      s3_tidx_r <= s2_tidx_r;
      s3_tval_r <= s2_tval_r;
      s3_hl1_r  <= hl1;

      s4_kind_r <= s3_kind_r;
      s4_fx_r   <= s3_fx_r;
      s4_fy_r   <= s3_fy_r;
      s4_fz_r   <= s3_fz_r;
      s4_hl1_r  <= s3_hl1_r;
      s4_hl2_r  <= hl2;

      s5_kind_r <= s4_kind_r;
      s5_pre_r  <= pre;
      s5_flag_r <= flag;
      s5_u_r    <= fade_u;
      s5_w_r    <= fade_w;
      s5_s_r    <= fade_s;

      s6_kind_r <= s5_kind_r;
      s6_pre_r  <= s5_pre_r;
      s6_flag_r <= s5_flag_r;
      s6_prod_r <= prod;
      s6_u_r    <= s5_u_r;
      s6_w_r    <= s5_w_r;
      s6_s_r    <= s5_s_r;

      s7_kind_r <= s6_kind_r;
      for (int j = 0; j < 4; j++) begin
        s7_xa_r[j] <= corner[j];
        s7_xm_r[j] <= xm[j];
      end
      s7_w_r    <= s6_w_r;
      s7_s_r    <= s6_s_r;

      s8_kind_r <= s7_kind_r;
      s8_x0_r   <= xl[0];
      for (int k = 0; k < 2; k++) begin
        s8_ya_r[k] <= xl[k];
        s8_ym_r[k] <= ym[k];
      end
      s8_s_r    <= s7_s_r;

      s9_kind_r <= s8_kind_r;
      s9_x0_r   <= s8_x0_r;
      s9_y0_r   <= yl[0];
      s9_za_r   <= yl[0];
      s9_zm_r   <= zm;

      s10_kind_r <= s9_kind_r;
      s10_fin_r  <= fin;

      out_noise_value_r <= sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  // A result only ever follows an evaluate request leaving the last stage.
  a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    en && !(s10_v_r && (s10_kind_r == gnl_pkg::KIND_EVAL)) |=> !out_valid_r)
    else $error("result produced without an evaluate request");

  // A held result freezes every stage of the pipe.
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r,
                     s7_v_r, s8_v_r, s9_v_r, s10_v_r}))
    else $error("pipeline moved while the result was stalled");

  // A request is only taken when the output slot can drain.
  a_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !(out_valid_r && out_stall))
    else $error("request accepted while the output was held");

endmodule
`default_nettype wire
